// ===== sv/stavs_pkg.sv =====
// Shared types and constants for the stable analog smoother.
// Holds the configuration register layout, register indexes, mode codes and
// the fixed-point constants of the hall mapping. No dependencies.
`default_nettype none

package stavs_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_MODE         = 3'd0;
  localparam logic [2:0] REG_SCALER_SHIFT = 3'd1;
  localparam logic [2:0] REG_MIN_CHANGE   = 3'd2;
  localparam logic [2:0] REG_STICK        = 3'd3;
  localparam logic [2:0] REG_SKIP_FIRST   = 3'd4;

  // Sample interpretation modes.
  localparam logic [1:0] MODE_ANALOG = 2'd0;
  localparam logic [1:0] MODE_TOUCH  = 2'd1;
  localparam logic [1:0] MODE_HALL   = 2'd2;
  localparam logic [1:0] MODE_RSVD   = 2'd3;

  // Register values after reset.
  localparam logic [1:0] RST_MODE         = MODE_ANALOG;
  localparam logic [3:0] RST_SCALER_SHIFT = 4'd4;
  localparam logic [7:0] RST_MIN_CHANGE   = 8'd0;
  localparam logic [7:0] RST_STICK        = 8'd0;
  localparam logic [7:0] RST_SKIP_FIRST   = 8'd16;

  // Hall mapping: (x * 43965 + 1100000) / 10000, i.e. x * 4.3965 + 110.
  localparam int HALL_W = 31;
  localparam logic signed [HALL_W-1:0] HALL_GAIN   = 31'sd43965;
  localparam logic signed [HALL_W-1:0] HALL_OFFSET = 31'sd1100000;
  // Numerator at or above this value maps beyond full scale.
  localparam logic signed [HALL_W-1:0] HALL_SAT_LIM = 31'sd2560000;
  // Below the limit the numerator fits this many bits.
  localparam int HALL_NUM_W = 22;
  // Reciprocal of 10000 scaled by 2^36; exact for numerators below 2^22.
  localparam int HALL_RECIP_W = 23;
  localparam logic [HALL_RECIP_W-1:0] HALL_RECIP = 23'd6871948;
  localparam int HALL_RECIP_SH = 36;

  // Held value handling.
  localparam int HELD_W = 10;
  localparam logic [7:0] FULL_SCALE = 8'd255;
  localparam logic signed [10:0] FORCE_STEP = 11'sd100;

  // Configuration register set.
  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] scaler_shift;
    logic [7:0] min_change;
    logic [7:0] stick;
    logic [7:0] skip_first;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/stable_analog_smoother.sv =====
// Stable analog smoother: scaled moving average with deadband and end snap.
// Beats pass the scaler stages and the window, average and output registers;
// throughput is one beat per cycle while m_tready holds, as each stage hands
// on one item per cycle, so a new sample can enter every cycle unless stalled.
// Reset clears the window, running sum, held value and priming count, and
// loads the configuration registers with their defaults.
`default_nettype none

module stable_analog_smoother #(
  parameter int WINDOW_LEN = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream; s_tdata: sample [12:0], zero [15:13].
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  // Output stream; m_tdata: raw_average [7:0], change [15:8], held_value [23:16].
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  // m_tuser: settled [0].
  output logic        m_tuser,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int SUM_W   = $clog2(WINDOW_LEN * 255 + 1);
  localparam int LEN_W   = $clog2(WINDOW_LEN);
  localparam int RECIP_SH = SUM_W + LEN_W;
  localparam int RECIP_W = RECIP_SH + 1;
  localparam int RECIP   = ((1 << RECIP_SH) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int AVG_PROD_W = SUM_W + RECIP_W;

  stavs_pkg::cfg_t cfg_q;

  logic             sc_valid;
  logic             sc_ready;
  logic [7:0]       sc_data;
  logic             win_valid;
  logic             win_ready;
  logic [SUM_W-1:0] win_sum;
  logic             keep_slot;

  logic                  avg_val_q;
  logic                  avg_ready;
  logic [7:0]            avg_q;
  logic [AVG_PROD_W-1:0] avg_prod;

  logic                                out_val_q;
  logic                                out_ready;
  logic                                out_load;
  logic signed [stavs_pkg::HELD_W-1:0] held_q;
  logic signed [stavs_pkg::HELD_W-1:0] held_d;
  logic [8:0]                          prime_q;
  logic [8:0]                          prime_d;
  logic                                priming;
  logic                                forcing;
  logic signed [10:0]                  avg_s;
  logic signed [10:0]                  base_s;
  logic signed [10:0]                  diff_s;
  logic [8:0]                          diff_abs;
  logic                                upd;
  logic signed [10:0]                  snap_s;
  logic signed [10:0]                  stick_s;
  logic signed [10:0]                  top_s;
  logic [7:0]                          change_d;
  logic [7:0]                          held_val_d;
  logic                                settled_d;
  logic [7:0]                          raw_avg_q;
  logic [7:0]                          change_q;
  logic [7:0]                          held_val_q;
  logic                                settled_q;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= stavs_pkg::RST_MODE;
      cfg_q.scaler_shift <= stavs_pkg::RST_SCALER_SHIFT;
      cfg_q.min_change   <= stavs_pkg::RST_MIN_CHANGE;
      cfg_q.stick        <= stavs_pkg::RST_STICK;
      cfg_q.skip_first   <= stavs_pkg::RST_SKIP_FIRST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        stavs_pkg::REG_MODE:         cfg_q.mode         <= cfg_data_i[1:0];
        stavs_pkg::REG_SCALER_SHIFT: cfg_q.scaler_shift <= cfg_data_i[3:0];
        stavs_pkg::REG_MIN_CHANGE:   cfg_q.min_change   <= cfg_data_i;
        stavs_pkg::REG_STICK:        cfg_q.stick        <= cfg_data_i;
        stavs_pkg::REG_SKIP_FIRST:   cfg_q.skip_first   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Scaling stages.
  stavs_scaler u_scaler (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .valid_i  (s_tvalid),
    .ready_o  (s_tready),
    .sample_i (s_tdata[12:0]),
    .valid_o  (sc_valid),
    .ready_i  (sc_ready),
    .scaled_o (sc_data)
  );

  // Window of cells with running sum.
  assign keep_slot = (cfg_q.mode == stavs_pkg::MODE_RSVD);

  stavs_window #(
    .WINDOW_LEN (WINDOW_LEN),
    .SUM_W      (SUM_W)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sc_valid),
    .ready_o (sc_ready),
    .data_i  (sc_data),
    .keep_i  (keep_slot),
    .valid_o (win_valid),
    .ready_i (win_ready),
    .sum_o   (win_sum)
  );

  // Average stage: sum divided by the window length through its reciprocal.
  assign avg_prod  = AVG_PROD_W'(win_sum) * AVG_PROD_W'(RECIP_W'(RECIP));
  assign avg_ready = !avg_val_q || out_ready;
  assign win_ready = avg_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_val_q <= 1'b0;
    end else if (avg_ready) begin
      avg_val_q <= win_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (avg_ready && win_valid) begin
      avg_q <= avg_prod[RECIP_SH +: 8];
    end
  end

  // Held value: priming, forced first update, deadband and end snapping.
  always_comb begin
    avg_s   = signed'({3'b000, avg_q});
    stick_s = signed'({3'b000, cfg_q.stick});
    top_s   = signed'({3'b000, stavs_pkg::FULL_SCALE - cfg_q.stick});
    priming = (prime_q < {1'b0, cfg_q.skip_first});
    forcing = (prime_q == {1'b0, cfg_q.skip_first});
    base_s  = forcing ? (avg_s - stavs_pkg::FORCE_STEP) : 11'(held_q);
    diff_s  = avg_s - base_s;
    diff_abs = diff_s[10] ? 9'(-diff_s) : diff_s[8:0];
    upd     = (diff_abs > {1'b0, cfg_q.min_change});
    snap_s  = upd ? avg_s : base_s;
    if (snap_s < stick_s) begin
      snap_s = '0;
    end
    if (snap_s > top_s) begin
      snap_s = signed'({3'b000, stavs_pkg::FULL_SCALE});
    end
    if (priming) begin
      held_d     = stavs_pkg::HELD_W'(avg_s);
      prime_d    = prime_q + 9'd1;
      change_d   = 8'd0;
      held_val_d = 8'd0;
      settled_d  = 1'b0;
    end else begin
      held_d     = snap_s[stavs_pkg::HELD_W-1:0];
      prime_d    = forcing ? prime_q + 9'd1 : prime_q;
      change_d   = !upd ? 8'd0 :
                   (diff_abs[8] ? stavs_pkg::FULL_SCALE : diff_abs[7:0]);
      held_val_d = snap_s[7:0];
      settled_d  = 1'b1;
    end
  end

  // Output register; it takes a new beat while the old one is leaving.
  assign out_ready = !out_val_q || m_tready;
  assign out_load  = avg_val_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_val_q <= 1'b0;
      held_q    <= '0;
      prime_q   <= '0;
    end else begin
      if (out_ready) begin
        out_val_q <= avg_val_q;
      end
      if (out_load) begin
        held_q  <= held_d;
        prime_q <= prime_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      raw_avg_q  <= avg_q;
      change_q   <= change_d;
      held_val_q <= held_val_d;
      settled_q  <= settled_d;
    end
  end

  assign m_tvalid = out_val_q;
  assign m_tdata  = {held_val_q, change_q, raw_avg_q};
  assign m_tuser  = settled_q;

endmodule

`default_nettype wire

// ===== sv/stavs_cell.sv =====
// One cell of the averaging window: a byte register that takes its
// neighbor's value on every shift. Depends on nothing.
`default_nettype none

module stavs_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] d_i,
  output logic [7:0] q_o
);

  logic [7:0] val_q;

  // The window starts cleared, so the cell value resets to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= 8'd0;
    end else if (en_i) begin
      val_q <= d_i;
    end
  end

  assign q_o = val_q;

endmodule

`default_nettype wire

// ===== sv/stavs_scaler.sv =====
// Two-stage sample scaler: shift or hall linear map, saturated to 0..255, or zero in the reserved mode.
// Uses stavs_pkg for the configuration type, mode codes and hall constants.
`default_nettype none

module stavs_scaler (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stavs_pkg::cfg_t    cfg_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [12:0]        sample_i,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [7:0]         scaled_o
);

  localparam int PROD_W = stavs_pkg::HALL_NUM_W + stavs_pkg::HALL_RECIP_W;

  logic                                 s1_val_q;
  logic                                 s1_ready;
  logic                                 s2_ready;
  logic signed [stavs_pkg::HALL_W-1:0]  hall_d;
  logic signed [stavs_pkg::HALL_W-1:0]  hall_q;
  logic [12:0]                          shifted;
  logic [7:0]                           shift_byte_d;
  logic [7:0]                           shift_byte_q;
  logic signed [12:0]                   x_s;
  logic [PROD_W-1:0]                    quot_prod;
  logic [7:0]                           hall_byte;
  logic [7:0]                           scaled_d;
  logic                                 s2_val_q;
  logic [7:0]                           scaled_q;

  // Stage one: shift with saturation, and the hall numerator product.
  always_comb begin
    x_s          = signed'(sample_i);
    shifted      = sample_i >> cfg_i.scaler_shift;
    shift_byte_d = (|shifted[12:8]) ? stavs_pkg::FULL_SCALE : shifted[7:0];
    hall_d       = stavs_pkg::HALL_W'(x_s) * stavs_pkg::HALL_GAIN
                   + stavs_pkg::HALL_OFFSET;
  end

  assign s2_ready = !s2_val_q || ready_i;
  assign s1_ready = !s1_val_q || s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_val_q <= 1'b0;
    end else if (s1_ready) begin
      s1_val_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && valid_i) begin
      hall_q       <= hall_d;
      shift_byte_q <= shift_byte_d;
    end
  end

  // Stage two: divide the hall numerator by 10000 through its reciprocal.
  always_comb begin
    quot_prod = PROD_W'(hall_q[stavs_pkg::HALL_NUM_W-1:0]) * PROD_W'(stavs_pkg::HALL_RECIP);
    if (hall_q < 0) begin
      hall_byte = 8'd0;
    end else if (hall_q >= stavs_pkg::HALL_SAT_LIM) begin
      hall_byte = stavs_pkg::FULL_SCALE;
    end else begin
      hall_byte = quot_prod[stavs_pkg::HALL_RECIP_SH +: 8];
    end
    unique case (cfg_i.mode)
      stavs_pkg::MODE_ANALOG: scaled_d = shift_byte_q;
      stavs_pkg::MODE_TOUCH:  scaled_d = shift_byte_q;
      stavs_pkg::MODE_HALL:   scaled_d = hall_byte;
      default:                scaled_d = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_val_q <= 1'b0;
    end else if (s2_ready) begin
      s2_val_q <= s1_val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_val_q) begin
      scaled_q <= scaled_d;
    end
  end

  assign ready_o  = s1_ready;
  assign valid_o  = s2_val_q;
  assign scaled_o = scaled_q;

endmodule

`default_nettype wire

// ===== sv/stavs_window.sv =====
// Averaging window built as a chain of byte cells plus the running sum.
// Uses stavs_cell for the cells; the oldest value falls off the chain end.
`default_nettype none

module stavs_window #(
  parameter int WINDOW_LEN = 16,
  parameter int SUM_W      = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [7:0]       data_i,
  input  logic             keep_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [SUM_W-1:0] sum_o
);

  logic [7:0]       cell_d [WINDOW_LEN];
  logic [7:0]       cell_q [WINDOW_LEN];
  logic [7:0]       tail;
  logic [7:0]       entry;
  logic             shift_en;
  logic             val_q;
  logic [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0] sum_d;

  assign ready_o  = !val_q || ready_i;
  assign shift_en = valid_i && ready_o;
  assign tail     = cell_q[WINDOW_LEN-1];

  // In the reserved mode the oldest value re-enters, so the sum holds.
  assign entry = keep_i ? tail : data_i;
  assign sum_d = sum_q - SUM_W'(tail) + SUM_W'(entry);

  // Each cell passes its byte to the next on every accepted beat.
  for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_d[k] = entry;
    end else begin : g_body
      assign cell_d[k] = cell_q[k-1];
    end
    stavs_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (shift_en),
      .d_i    (cell_d[k]),
      .q_o    (cell_q[k])
    );
  end

  // The running sum doubles as this stage's output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= 1'b0;
      sum_q <= '0;
    end else begin
      if (ready_o) begin
        val_q <= valid_i;
      end
      if (shift_en) begin
        sum_q <= sum_d;
      end
    end
  end

  assign valid_o = val_q;
  assign sum_o   = sum_q;

endmodule

`default_nettype wire

// ===== tb/sv/stable_analog_smoother_test.sv =====
// Self-checking testbench for the stable analog smoother.
// Depends on stavs_pkg and stable_analog_smoother; a scoreboard class predicts
// every output beat from the accepted samples and the register settings.
`default_nettype none

module stable_analog_smoother_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_LEN = 16;
  // Indexes above the last register; writes there must be ignored.
  localparam logic [2:0] REG_FIRST_UNUSED = 3'd5;
  localparam int HALL_DIVISOR = 10000;

  // One expected output beat.
  typedef struct {
    logic [7:0] raw_average;
    logic [7:0] change;
    logic [7:0] held_value;
    logic       settled;
  } smooth_result_t;

  // Predicts the smoother and checks its output beats in order.
  class smoother_scoreboard;
    stavs_pkg::cfg_t regs;
    logic [7:0]      ring [WINDOW_LEN];
    int              ring_sum;
    int              slot;
    int              held;
    int              primed_count;
    smooth_result_t  pending_beats [$];
    int              fail_count;

    function new();
      regs.mode         = stavs_pkg::RST_MODE;
      regs.scaler_shift = stavs_pkg::RST_SCALER_SHIFT;
      regs.min_change   = stavs_pkg::RST_MIN_CHANGE;
      regs.stick        = stavs_pkg::RST_STICK;
      regs.skip_first   = stavs_pkg::RST_SKIP_FIRST;
      foreach (ring[i]) ring[i] = '0;
      ring_sum     = 0;
      slot         = 0;
      held         = 0;
      primed_count = 0;
      fail_count   = 0;
    endfunction

    function void apply_register(logic [2:0] index, logic [7:0] value);
      case (index)
        stavs_pkg::REG_MODE:         regs.mode = value[1:0];
        stavs_pkg::REG_SCALER_SHIFT: regs.scaler_shift = value[3:0];
        stavs_pkg::REG_MIN_CHANGE:   regs.min_change = value;
        stavs_pkg::REG_STICK:        regs.stick = value;
        stavs_pkg::REG_SKIP_FIRST:   regs.skip_first = value;
        default: ;
      endcase
    endfunction

    // Maps one sample to the 0..255 scale of the window.
    function logic [7:0] scale_sample(logic [12:0] sample);
      longint      numer;
      logic [12:0] shifted;
      if (regs.mode == stavs_pkg::MODE_HALL) begin
        numer = longint'($signed(sample)) * longint'(stavs_pkg::HALL_GAIN)
                + longint'(stavs_pkg::HALL_OFFSET);
        if (numer < 0) return 8'd0;
        numer = numer / HALL_DIVISOR;
        return (numer > 255) ? stavs_pkg::FULL_SCALE : numer[7:0];
      end
      shifted = sample >> regs.scaler_shift;
      return (shifted > 13'd255) ? stavs_pkg::FULL_SCALE : shifted[7:0];
    endfunction

    // Advances the predicted state by one accepted sample.
    function void note_sample(logic [12:0] sample);
      smooth_result_t r;
      int             avg;
      int             diff;
      // The reserved mode leaves the ring slot untouched but still steps on.
      if (regs.mode != stavs_pkg::MODE_RSVD) begin
        ring_sum   = ring_sum - int'(ring[slot]);
        ring[slot] = scale_sample(sample);
        ring_sum   = ring_sum + int'(ring[slot]);
      end
      slot = (slot + 1) % WINDOW_LEN;
      avg  = ring_sum / WINDOW_LEN;

      r.raw_average = avg[7:0];
      r.change      = '0;
      r.held_value  = '0;
      r.settled     = 1'b0;
      if (primed_count < int'(regs.skip_first)) begin
        primed_count++;
        held = avg;
      end else begin
        // The first settled beat compares the average against a held value FORCE_STEP below it.
        if (primed_count == int'(regs.skip_first)) begin
          primed_count++;
          held = avg - int'(stavs_pkg::FORCE_STEP);
        end
        diff = (avg > held) ? avg - held : held - avg;
        if (diff > int'(regs.min_change)) begin
          r.change = (diff > 255) ? stavs_pkg::FULL_SCALE : diff[7:0];
          held     = avg;
        end
        if (held < int'(regs.stick)) held = 0;
        if (held > 255 - int'(regs.stick)) held = 255;
        r.held_value = held[7:0];
        r.settled    = 1'b1;
      end
      pending_beats.push_back(r);
    endfunction

    function void compare_field(string field, int expected, int actual);
      if (expected != actual) begin
        $error("%s mismatch: expected %0d, got %0d", field, expected, actual);
        fail_count++;
      end
    endfunction

    function void check_beat(logic [23:0] beat, logic settled);
      smooth_result_t r;
      if (pending_beats.size() == 0) begin
        $error("output beat %h with settled %b arrived with nothing expected", beat, settled);
        fail_count++;
        return;
      end
      r = pending_beats.pop_front();
      compare_field("raw_average", r.raw_average, beat[7:0]);
      compare_field("change", r.change, beat[15:8]);
      compare_field("held_value", r.held_value, beat[23:16]);
      compare_field("settled", r.settled, settled);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;

  smoother_scoreboard board;
  int unsigned        burst_left;
  int unsigned        sample_count;
  int                 walk_level;

  stable_analog_smoother #(
    .WINDOW_LEN(WINDOW_LEN)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Output side: runs of steady readiness, stall stretches and choppy spells.
  initial begin
    int unsigned run_left;
    m_tready = 1'b0;
    run_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (run_left == 0) begin
        case ($urandom_range(0, 3))
          0: begin
            m_tready = 1'b1;
            run_left = $urandom_range(20, 200);
          end
          1: begin
            m_tready = 1'b0;
            run_left = $urandom_range(1, 20);
          end
          default: begin
            m_tready = 1'($urandom_range(0, 1));
            run_left = $urandom_range(1, 4);
          end
        endcase
      end
      run_left--;
    end
  end

  // Every accepted output beat is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) board.check_beat(m_tdata, m_tuser);
  end

  // Sends one sample beat; the sender may idle between bursts of random length.
  task automatic push_sample(input logic [12:0] sample);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
    s_tvalid = 1'b1;
    s_tdata  = {3'b000, sample};
    do @(posedge clk_i); while (!s_tready);
    board.note_sample(sample);
    sample_count++;
    burst_left--;
    @(negedge clk_i);
  endtask

  // Waits until every predicted beat has come out and the pipeline is empty.
  task automatic drain_results();
    while (board.pending_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_register(input logic [2:0] index, input logic [7:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = index;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.apply_register(index, value);
    @(negedge clk_i);
  endtask

  // Loads a full register set while the block is idle.
  task automatic program_settings(input logic [1:0] mode, input logic [3:0] shift,
                                  input logic [7:0] min_change, input logic [7:0] stick,
                                  input logic [7:0] skip);
    s_tvalid   = 1'b0;
    burst_left = 0;
    drain_results();
    write_register(stavs_pkg::REG_MODE, {6'd0, mode});
    write_register(stavs_pkg::REG_SCALER_SHIFT, {4'd0, shift});
    write_register(stavs_pkg::REG_MIN_CHANGE, min_change);
    write_register(stavs_pkg::REG_STICK, stick);
    write_register(stavs_pkg::REG_SKIP_FIRST, skip);
    if ($urandom_range(0, 3) == 0)
      write_register(3'($urandom_range(int'(REG_FIRST_UNUSED), 7)), 8'($urandom));
    cfg_valid_i = 1'b0;
  endtask

  // Slowly drifting samples with occasional jumps, so the deadband gets work.
  function automatic logic [12:0] next_sample(logic [1:0] mode, logic [3:0] shift);
    int span;
    if ($urandom_range(0, 7) == 0) begin
      walk_level = int'($urandom_range(0, 8191));
      if (mode == stavs_pkg::MODE_HALL) walk_level = walk_level - 4096;
      return walk_level[12:0];
    end
    if (mode == stavs_pkg::MODE_HALL) begin
      // The hall map only moves between about -25 and 33.
      if (walk_level < -40 || walk_level > 45) walk_level = int'($urandom_range(0, 85)) - 40;
      span = 3;
    end else begin
      span = (1 << shift) * 3;
    end
    walk_level = walk_level + int'($urandom_range(0, 2 * span)) - span;
    if (mode != stavs_pkg::MODE_HALL) begin
      if (walk_level < 0) walk_level = 0;
      if (walk_level > 8191) walk_level = 8191;
    end
    return walk_level[12:0];
  endfunction

  initial begin
    logic [12:0] analog_points [6];
    logic [12:0] hall_points [7];
    logic [1:0]  mode;
    logic [3:0]  shift;
    logic [7:0]  min_change;
    logic [7:0]  stick;
    logic [7:0]  skip;
    int          skip_near;
    int unsigned phase_len;

    board        = new();
    rst_ni       = 1'b0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    burst_left   = 0;
    sample_count = 0;
    walk_level   = 0;
    analog_points = '{13'd0, 13'h1FFF, 13'h1000, 13'd255, 13'd256, 13'd1};
    // Hall extremes, both sides of the zero crossing, and both sides of full scale.
    hall_points = '{13'h1000, 13'h0FFF, 13'(-25), 13'(-26), 13'd0, 13'd33, 13'd34};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Unshifted analog extremes; one priming beat, then the forced update.
    program_settings(stavs_pkg::MODE_ANALOG, 4'd0, 8'd0, 8'd0, 8'd1);
    foreach (analog_points[i]) push_sample(analog_points[i]);

    // Hall mapping with no priming at all.
    program_settings(stavs_pkg::MODE_HALL, 4'd0, 8'd0, 8'd0, 8'd0);
    foreach (hall_points[i]) push_sample(hall_points[i]);

    // Reserved mode keeps the ring, then touch with the widest shift.
    program_settings(stavs_pkg::MODE_RSVD, 4'd0, 8'd0, 8'd0, 8'd0);
    push_sample(13'h1FFF);
    push_sample(13'h0AAA);
    program_settings(stavs_pkg::MODE_TOUCH, 4'd15, 8'd255, 8'd0, 8'd0);
    repeat (3) push_sample(13'h1FFF);

    // Priming count reached again: forced update, with full-range snapping.
    program_settings(stavs_pkg::MODE_ANALOG, 4'd4, 8'd0, 8'd255, 8'd2);
    repeat (3) push_sample(13'($urandom));
    program_settings(stavs_pkg::MODE_ANALOG, 4'd8, 8'd255, 8'd128, 8'd0);
    repeat (3) push_sample(13'($urandom));

    // Random phases until enough samples have gone through.
    while (sample_count < 1725) begin
      if ($urandom_range(0, 9) == 0 && board.primed_count + 17 <= 255) begin
        // Prime on a near-empty ring, then climb to full scale against a
        // wide deadband.
        skip = 8'(board.primed_count + 16);
        program_settings(stavs_pkg::MODE_ANALOG, 4'd0, 8'($urandom_range(100, 255)),
                         8'($urandom_range(0, 5)), skip);
        repeat (17) push_sample(13'($urandom_range(0, 15)));
        repeat (20) push_sample(13'($urandom_range(255, 8191)));
      end else begin
        mode = ($urandom_range(0, 9) == 0) ? stavs_pkg::MODE_RSVD
                                           : 2'($urandom_range(0, 2));
        shift = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(0, 8));
        case ($urandom_range(0, 3))
          0: min_change = 8'd0;
          1: min_change = 8'd255;
          2: min_change = 8'($urandom_range(0, 20));
          default: min_change = 8'($urandom);
        endcase
        case ($urandom_range(0, 5))
          0: stick = 8'd255;
          1, 2: stick = 8'd0;
          3, 4: stick = 8'($urandom_range(0, 10));
          default: stick = 8'($urandom);
        endcase
        skip_near = board.primed_count + int'($urandom_range(0, 4));
        if (skip_near > 255) skip_near = 255;
        if (sample_count > 1400 && $urandom_range(0, 4) == 0) skip = 8'd255;
        else if ($urandom_range(0, 1) == 0) skip = 8'(skip_near);
        else skip = 8'($urandom_range(0, 20));
        program_settings(mode, shift, min_change, stick, skip);
        phase_len = $urandom_range(20, 120);
        repeat (phase_len) push_sample(next_sample(mode, shift));
      end
    end

    s_tvalid = 1'b0;
    drain_results();
    if (board.fail_count == 0 && board.pending_beats.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
sv/stavs_pkg.sv
sv/stavs_cell.sv
sv/stavs_scaler.sv
sv/stavs_window.sv
sv/stable_analog_smoother.sv
tb/sv/stable_analog_smoother_test.sv
